FILE: rtl/core/cdt_pkg.sv
// Shared constants, types and codes for the chamfer distance transform.
package cdt_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int DIST_BITS   = 32;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

  // Interface field widths
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 24;
  localparam int PIX_W      = 32;
  localparam int PADDR_W    = 16;
  localparam int OUT_W      = 32;
  localparam int LC_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Derived widths
  localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int TOT_W    = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W    = (TOT_W > LC_W) ? TOT_W : LC_W;
  localparam int SZ_MAX_W = (COLS_W > ROWS_W) ? COLS_W : ROWS_W;
  localparam int SZ_CMP_W = (SZ_MAX_W > SIZE_W) ? SZ_MAX_W : SIZE_W;
  localparam int SUM_W    = ((DIST_BITS > STEP_W) ? DIST_BITS : STEP_W) + 1;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam dist_t DIST_MAX = '1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_COLS    = 3'd0,
    CFG_HEIGHT_ROWS   = 3'd1,
    CFG_STEP_X        = 3'd2,
    CFG_STEP_Y        = 3'd3,
    CFG_STEP_DIAG     = 3'd4,
    CFG_NODATA_ENABLE = 3'd5,
    CFG_NODATA_VALUE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PRIME,
    ST_READ,
    ST_SUM,
    ST_MIN
  } state_t;

  // Which neighbors of the current pixel exist in the running pass
  typedef struct packed {
    logic has_row;
    logic has_behind;
    logic has_back_diag;
    logic has_ahead_diag;
  } nbr_mask_t;

endpackage

FILE: rtl/core/cdt_ram.sv
// Synchronous RAM with one write port and two registered read ports.
module cdt_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/cdt_relax.sv
// Relaxation datapath: saturating neighbor sums, then minimum with the pixel itself.
module cdt_relax
  import cdt_pkg::*;
(
  input  logic      clk,
  input  logic      load_en,
  input  nbr_mask_t mask,
  input  dist_t     self_d,
  input  dist_t     row_d,
  input  dist_t     back_d,
  input  dist_t     ahead_d,
  input  dist_t     behind_d,
  input  step_t     step_x,
  input  step_t     step_y,
  input  step_t     step_diag,
  output dist_t     best
);

  dist_t self_r;
  dist_t c_row_r;
  dist_t c_back_r;
  dist_t c_ahead_r;
  dist_t c_behind_r;
  dist_t m_a;
  dist_t m_b;
  dist_t m_c;

  function automatic dist_t sat_add(dist_t a, step_t s);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(s);
    if (sum > SUM_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_BITS'(sum);
  endfunction

  // Absent neighbors contribute all-ones, which never wins the minimum
  always_ff @(posedge clk) begin
    if (load_en) begin
      self_r     <= self_d;
      c_row_r    <= mask.has_row        ? sat_add(row_d, step_y)     : DIST_MAX;
      c_behind_r <= mask.has_behind     ? sat_add(behind_d, step_x)  : DIST_MAX;
      c_back_r   <= mask.has_back_diag  ? sat_add(back_d, step_diag) : DIST_MAX;
      c_ahead_r  <= mask.has_ahead_diag ? sat_add(ahead_d, step_diag) : DIST_MAX;
    end
  end

  always_comb begin
    m_a  = (c_row_r < self_r) ? c_row_r : self_r;
    m_b  = (c_ahead_r < c_back_r) ? c_ahead_r : c_back_r;
    m_c  = (m_b < m_a) ? m_b : m_a;
    best = (c_behind_r < m_c) ? c_behind_r : m_c;
  end

endmodule

FILE: rtl/core/chamfer_distance_transform_top.sv
// Chamfer distance transform: image load, two raster passes over the store, readback.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, in_kind, in_pixel_value,     | into block
//          | in_pixel_address                                 |
//  out     | out_valid, out_stall, out_distance, out_not_done | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | into block
//
// A load writes the store when it is accepted; a fetch reads the store, then moves its result into the output register.
// The last load of an image starts both passes: each pass primes every row, then does read, sum
// and min/write-back for each pixel of the row in the single store.
// Input is stalled during the passes; cfg_ready is high only while idle.
// Reset (rst_n low, synchronous) restores register defaults and clears the load count; the store keeps
// its contents. A fetch waits while an earlier result is held by out_stall; loads do not.
module chamfer_distance_transform_top
  import cdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic [PADDR_W-1:0]    in_pixel_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_distance,
  output logic                  out_not_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration
  logic [SIZE_W-1:0] width_cols_r;
  logic [SIZE_W-1:0] height_rows_r;
  step_t             step_x_r;
  step_t             step_y_r;
  step_t             step_diag_r;
  logic              nodata_enable_r;
  logic [PIX_W-1:0]  nodata_value_r;

  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [TOT_W-1:0]  total;

  state_t state_r;
  state_t state_nxt;

  logic [LC_W-1:0] load_count_r;
  logic            passes_done_r;
  logic [LC_W-1:0] lc_eff;
  logic [LC_W-1:0] lc_next;
  logic            load_start;
  logic            target;
  logic            in_acc;
  logic            cfg_acc;

  logic            fetch_hit_r;
  logic            fetch_nd_r;
  logic            out_valid_r;
  logic [OUT_W-1:0] out_distance_r;
  logic            out_not_done_r;

  // Pass position
  addr_t            idx_r;
  logic [COL_W-1:0] pos_c_r;
  logic [ROW_W-1:0] pos_r_r;
  logic             fwd_r;
  addr_t            cols_a;
  addr_t            row_addr;
  addr_t            ahead_addr;
  logic             last_col;
  logic             last_row;
  nbr_mask_t        mask;

  dist_t win_row_r;
  dist_t win_back_r;
  dist_t behind_r;
  dist_t best;

  // Store ports
  logic  mem_we;
  addr_t mem_waddr;
  dist_t mem_wdata;
  logic  mem_re_a;
  addr_t mem_raddr_a;
  dist_t mem_rdata_a;
  logic  mem_re_b;
  addr_t mem_raddr_b;
  dist_t mem_rdata_b;
  logic  relax_en;

  // Effective image size: zero counts as one, oversize clamps to the maximum
  always_comb begin
    if (width_cols_r == '0) begin
      eff_cols = COLS_W'(1);
    end else if (SZ_CMP_W'(width_cols_r) > SZ_CMP_W'(MAX_COLS)) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = COLS_W'(width_cols_r);
    end
    if (height_rows_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (SZ_CMP_W'(height_rows_r) > SZ_CMP_W'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = ROWS_W'(height_rows_r);
    end
  end

  assign total = TOT_W'(TOT_W'(eff_cols) * TOT_W'(eff_rows));

  assign in_acc  = in_valid && !in_stall;
  assign cfg_acc = cfg_valid && cfg_ready;

  assign lc_eff     = passes_done_r ? '0 : load_count_r;
  assign lc_next    = lc_eff + LC_W'(1);
  assign load_start = CMP_W'(lc_next) >= CMP_W'(total);
  assign target     = (in_pixel_value != '0) &&
                      (!nodata_enable_r || (in_pixel_value != nodata_value_r));

  assign cols_a     = ADDR_W'(eff_cols);
  assign row_addr   = fwd_r ? (idx_r - cols_a) : (idx_r + cols_a);
  assign ahead_addr = fwd_r ? (row_addr + ADDR_W'(1)) : (row_addr - ADDR_W'(1));
  assign last_col   = (COLS_W'(pos_c_r) + COLS_W'(1)) == eff_cols;
  assign last_row   = (ROWS_W'(pos_r_r) + ROWS_W'(1)) == eff_rows;

  always_comb begin
    mask.has_row        = pos_r_r != '0;
    mask.has_behind     = pos_c_r != '0;
    mask.has_back_diag  = (pos_r_r != '0) && (pos_c_r != '0);
    mask.has_ahead_diag = (pos_r_r != '0) && !last_col;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_FETCH) begin
            state_nxt = ST_FETCH;
          end else if (load_start) begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_FETCH: state_nxt = ST_IDLE;
      ST_PRIME: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_MIN;
      ST_MIN: begin
        if (!last_col) begin
          state_nxt = ST_READ;
        end else if (!last_row || fwd_r) begin
          state_nxt = ST_PRIME;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and store controls
  always_comb begin
    in_stall    = (state_r != ST_IDLE) ||
                  ((in_kind == KIND_FETCH) && out_valid_r && out_stall);
    cfg_ready   = state_r == ST_IDLE;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = best;
    mem_re_a    = 1'b0;
    mem_raddr_a = idx_r;
    mem_re_b    = 1'b0;
    mem_raddr_b = ahead_addr;
    relax_en    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_LOAD)) begin
          mem_we    = CMP_W'(lc_eff) < CMP_W'(STORE_DEPTH);
          mem_waddr = ADDR_W'(lc_eff);
          mem_wdata = target ? '0 : DIST_MAX;
        end
        if (in_acc && (in_kind == KIND_FETCH)) begin
          mem_re_a    = 1'b1;
          mem_raddr_a = ADDR_W'(in_pixel_address);
        end
      end
      ST_PRIME: begin
        mem_re_b    = 1'b1;
        mem_raddr_b = row_addr;
      end
      ST_READ: begin
        mem_re_a = 1'b1;
        mem_re_b = 1'b1;
      end
      ST_SUM: relax_en = 1'b1;
      ST_MIN: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      load_count_r    <= '0;
      passes_done_r   <= 1'b0;
      out_valid_r     <= 1'b0;
      width_cols_r    <= SIZE_W'(256);
      height_rows_r   <= SIZE_W'(256);
      step_x_r        <= STEP_W'(256);
      step_y_r        <= STEP_W'(256);
      step_diag_r     <= STEP_W'(362);
      nodata_enable_r <= 1'b0;
      nodata_value_r  <= 32'hFFFF_D8F1;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        case (cfg_reg_t'(cfg_index))
          CFG_WIDTH_COLS:    width_cols_r    <= cfg_data[SIZE_W-1:0];
          CFG_HEIGHT_ROWS:   height_rows_r   <= cfg_data[SIZE_W-1:0];
          CFG_STEP_X:        step_x_r        <= cfg_data[STEP_W-1:0];
          CFG_STEP_Y:        step_y_r        <= cfg_data[STEP_W-1:0];
          CFG_STEP_DIAG:     step_diag_r     <= cfg_data[STEP_W-1:0];
          CFG_NODATA_ENABLE: nodata_enable_r <= cfg_data[0];
          CFG_NODATA_VALUE:  nodata_value_r  <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end

      // A new load after finished passes restarts the image
      if ((state_r == ST_IDLE) && in_acc && (in_kind == KIND_LOAD)) begin
        load_count_r  <= lc_next;
        passes_done_r <= 1'b0;
      end

      if ((state_r == ST_MIN) && last_col && last_row && !fwd_r) begin
        passes_done_r <= 1'b1;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FETCH) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Pass sequencing and window registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_LOAD) && load_start) begin
          fwd_r   <= 1'b1;
          idx_r   <= '0;
          pos_c_r <= '0;
          pos_r_r <= '0;
        end
        if (in_acc && (in_kind == KIND_FETCH)) begin
          fetch_hit_r <= passes_done_r &&
                         (CMP_W'(in_pixel_address) < CMP_W'(total)) &&
                         (CMP_W'(in_pixel_address) < CMP_W'(STORE_DEPTH));
          fetch_nd_r  <= !passes_done_r;
        end
      end
      ST_FETCH: begin
        out_distance_r <= fetch_hit_r ? OUT_W'(mem_rdata_a) : '0;
        out_not_done_r <= fetch_nd_r;
      end
      ST_READ: begin
        // Row neighbor primed at the start of the row
        if (pos_c_r == '0) begin
          win_row_r <= mem_rdata_b;
        end
      end
      ST_MIN: begin
        behind_r   <= best;
        win_back_r <= win_row_r;
        win_row_r  <= mem_rdata_b;
        if (!last_col) begin
          pos_c_r <= pos_c_r + COL_W'(1);
          idx_r   <= fwd_r ? (idx_r + ADDR_W'(1)) : (idx_r - ADDR_W'(1));
        end else if (!last_row) begin
          pos_c_r <= '0;
          pos_r_r <= pos_r_r + ROW_W'(1);
          idx_r   <= fwd_r ? (idx_r + ADDR_W'(1)) : (idx_r - ADDR_W'(1));
        end else if (fwd_r) begin
          // Turn around: backward pass starts at the last pixel
          fwd_r   <= 1'b0;
          idx_r   <= ADDR_W'(total - TOT_W'(1));
          pos_c_r <= '0;
          pos_r_r <= '0;
        end
      end
      default: ;
    endcase
  end

  cdt_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DIST_BITS),
    .AW    (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re_a    (mem_re_a),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .re_b    (mem_re_b),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  cdt_relax u_relax (
    .clk       (clk),
    .load_en   (relax_en),
    .mask      (mask),
    .self_d    (mem_rdata_a),
    .row_d     (win_row_r),
    .back_d    (win_back_r),
    .ahead_d   (mem_rdata_b),
    .behind_d  (behind_r),
    .step_x    (step_x_r),
    .step_y    (step_y_r),
    .step_diag (step_diag_r),
    .best      (best)
  );

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_not_done = out_not_done_r;

  // Write-back never raises a distance above the value read for that pixel
  a_min_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIN) |-> (best <= mem_rdata_a))
    else $error("relaxed distance exceeds stored distance");

  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |=> out_valid_r)
    else $error("fetch transaction produced no result");

  a_done_after_backward: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(passes_done_r) |-> (($past(state_r) == ST_MIN) && !$past(fwd_r)))
    else $error("passes flagged done outside end of backward pass");

  a_prime_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRIME) |-> (pos_c_r == '0))
    else $error("row prime away from first column");

endmodule
